FILE: design/bank_switch_scanline_irq_mapper_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bank switch mapper
// Shared concurrent assertion forms, all reset-qualified.
// ---------------------------------------------------------------------------
`ifndef BANK_SWITCH_SCANLINE_IRQ_MAPPER_TOP_MACROS_SVH
`define BANK_SWITCH_SCANLINE_IRQ_MAPPER_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define BSSIM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bssim assertion failed");

// Antecedent implies consequent in the following cycle.
`define BSSIM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bssim assertion failed");

`endif

FILE: design/bssim_pkg.sv
// ---------------------------------------------------------------------------
// bssim_pkg
// Types, constants and register decode codes for the bank switch mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package bssim_pkg;

  // Reset value of the per-line counter decrement.
  localparam logic [7:0] TicksResetVal = 8'd113;

  // APB register indexes.
  localparam logic RegTicksPerLine = 1'b0;

  // Item kinds.
  localparam logic ModeBusWrite = 1'b0;
  localparam logic ModeTick     = 1'b1;

  // Write decode on address bits 15..11.
  typedef enum logic [4:0] {
    SelChr0   = 5'h11,
    SelChr1   = 5'h13,
    SelChr2   = 5'h15,
    SelChr3   = 5'h17,
    SelIrqCnt = 5'h19,
    SelIrqEn  = 5'h1B,
    SelMirror = 5'h1D,
    SelPrg    = 5'h1F
  } reg_sel_e;

  // One input request.
  typedef struct packed {
    logic        mode;
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

  // One result request.
  typedef struct packed {
    logic [7:0]  prg_bank;
    logic [7:0]  chr_bank_0;
    logic [7:0]  chr_bank_1;
    logic [7:0]  chr_bank_2;
    logic [7:0]  chr_bank_3;
    logic [1:0]  mirroring;
    logic        irq_pulse;
    logic        irq_active;
    logic [15:0] irq_count;
  } result_t;

endpackage

`default_nettype wire

FILE: design/bssim_in_reg.sv
// ---------------------------------------------------------------------------
// bssim_in_reg
// Input register: holds one accepted request until the core takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module bssim_in_reg (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire bssim_pkg::item_t  item_i,
  input  wire                    down_ready_i,
  output logic                   valid_o,
  output bssim_pkg::item_t       item_o
);

  logic             valid_q, valid_d;
  bssim_pkg::item_t item_q;

  // The register frees up whenever its content moves on this cycle.
  assign in_ready_o = !valid_q || down_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload is loaded on every accepted request.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: design/bssim_core.sv
// ---------------------------------------------------------------------------
// bssim_core
// Mapper state: bank registers, mirroring and the IRQ down-counter.
// Computes the state after one request and commits it when the request moves.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bank_switch_scanline_irq_mapper_top_macros.svh"

module bssim_core (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    adv_i,
  input  wire bssim_pkg::item_t  item_i,
  input  wire  [7:0]             ticks_i,
  output bssim_pkg::result_t     res_o
);

  logic [7:0]  prg_q, prg_d;
  logic [7:0]  chr0_q, chr0_d, chr1_q, chr1_d, chr2_q, chr2_d, chr3_q, chr3_d;
  logic [1:0]  mir_q, mir_d;
  logic        en_q, en_d;
  logic        lo_next_q, lo_next_d;
  logic [15:0] cnt_q, cnt_d;
  logic        pulse;
  logic        borrow;
  logic [15:0] cnt_sub;

  // A borrow happens when the counter is below the step.
  assign borrow  = cnt_q < {8'd0, ticks_i};
  assign cnt_sub = cnt_q - {8'd0, ticks_i};

  // Next state for the request sitting in the input register.
  always_comb begin
    prg_d     = prg_q;
    chr0_d    = chr0_q;
    chr1_d    = chr1_q;
    chr2_d    = chr2_q;
    chr3_d    = chr3_q;
    mir_d     = mir_q;
    en_d      = en_q;
    lo_next_d = lo_next_q;
    cnt_d     = cnt_q;
    pulse     = 1'b0;
    if (item_i.mode == bssim_pkg::ModeBusWrite) begin
      unique case (bssim_pkg::reg_sel_e'(item_i.addr[15:11]))
        bssim_pkg::SelChr0:   chr0_d = item_i.data;
        bssim_pkg::SelChr1:   chr1_d = item_i.data;
        bssim_pkg::SelChr2:   chr2_d = item_i.data;
        bssim_pkg::SelChr3:   chr3_d = item_i.data;
        bssim_pkg::SelIrqCnt: begin
          if (lo_next_q) begin
            cnt_d = {cnt_q[15:8], item_i.data};
          end else begin
            cnt_d = {item_i.data, cnt_q[7:0]};
          end
          lo_next_d = !lo_next_q;
        end
        bssim_pkg::SelIrqEn: begin
          en_d      = item_i.data[4];
          lo_next_d = 1'b0;
        end
        bssim_pkg::SelMirror: mir_d = item_i.data[1:0];
        bssim_pkg::SelPrg:    prg_d = item_i.data;
        default: ;
      endcase
    end else if (en_q) begin
      cnt_d = cnt_sub;
      if (borrow) begin
        en_d  = 1'b0;
        pulse = 1'b1;
      end
    end
  end

  // State registers, committed when the request moves to the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_q     <= '0;
      chr0_q    <= '0;
      chr1_q    <= '0;
      chr2_q    <= '0;
      chr3_q    <= '0;
      mir_q     <= '0;
      en_q      <= 1'b0;
      lo_next_q <= 1'b0;
      cnt_q     <= '0;
    end else if (adv_i) begin
      prg_q     <= prg_d;
      chr0_q    <= chr0_d;
      chr1_q    <= chr1_d;
      chr2_q    <= chr2_d;
      chr3_q    <= chr3_d;
      mir_q     <= mir_d;
      en_q      <= en_d;
      lo_next_q <= lo_next_d;
      cnt_q     <= cnt_d;
    end
  end

  // The result shows the state after this request.
  always_comb begin
    res_o.prg_bank   = prg_d;
    res_o.chr_bank_0 = chr0_d;
    res_o.chr_bank_1 = chr1_d;
    res_o.chr_bank_2 = chr2_d;
    res_o.chr_bank_3 = chr3_d;
    res_o.mirroring  = mir_d;
    res_o.irq_pulse  = pulse;
    res_o.irq_active = en_d;
    res_o.irq_count  = cnt_d;
  end

  // An IRQ pulse always stops counting.
  `BSSIM_ASSERT_SAME(a_pulse_disables, clk_i, rst_ni, adv_i && pulse, !en_d)
  // Only a tick can raise the IRQ pulse.
  `BSSIM_ASSERT_SAME(a_pulse_on_tick, clk_i, rst_ni, pulse, item_i.mode == bssim_pkg::ModeTick)
  // A tick while counting is stopped leaves the counter alone.
  `BSSIM_ASSERT_NEXT(a_idle_tick_holds, clk_i, rst_ni, adv_i && !en_q && item_i.mode == bssim_pkg::ModeTick, $stable(cnt_q) && !en_q)

endmodule

`default_nettype wire

FILE: design/bssim_out_reg.sv
// ---------------------------------------------------------------------------
// bssim_out_reg
// Result register: holds one finished result until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module bssim_out_reg (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      load_i,
  input  wire bssim_pkg::result_t  res_i,
  output logic                     ready_o,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output bssim_pkg::result_t       res_o
);

  logic               valid_q, valid_d;
  bssim_pkg::result_t res_q;

  // A new result may enter when the register is empty or being drained.
  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

FILE: design/bank_switch_scanline_irq_mapper_top.sv
// ---------------------------------------------------------------------------
// bank_switch_scanline_irq_mapper_top
// Bank switching mapper with a scanline-driven IRQ down-counter.
// Input channel (in_valid_i/in_ready_o): one request is either a CPU bus
// write (mode 0, addr, data) or a scanline tick (mode 1). Output channel
// (out_valid_o/out_ready_i): one result per request with the bank registers,
// mirroring, IRQ pulse, IRQ enable and counter value after that request.
// The input register comes first, then the result register. Throughput is
// one request per cycle while out_ready_i stays high; the state update is
// one 16-bit subtract and compare between the two registers. When the
// receiver stalls, the result register holds its result and the input
// register takes one more request, after which in_ready_o drops. Reset
// clears all bank, mirroring and counter state, empties both stages and
// sets ticks_per_line to 113. APB register ticks_per_line sits at address 0
// and must be written only while the block is idle; nothing enforces it.
// ---------------------------------------------------------------------------
`default_nettype none

module bank_switch_scanline_irq_mapper_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  // APB configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         mode_i,
  input  wire  [15:0] addr_i,
  input  wire  [7:0]  data_i,
  // Output channel
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  prg_bank_o,
  output logic [7:0]  chr_bank_0_o,
  output logic [7:0]  chr_bank_1_o,
  output logic [7:0]  chr_bank_2_o,
  output logic [7:0]  chr_bank_3_o,
  output logic [1:0]  mirroring_o,
  output logic        irq_pulse_o,
  output logic        irq_active_o,
  output logic [15:0] irq_count_o
);

  logic [7:0]         ticks_q;
  logic               cfg_wr;
  bssim_pkg::item_t   in_item;
  bssim_pkg::item_t   s1_item;
  logic               s1_valid;
  logic               s2_ready;
  logic               adv;
  bssim_pkg::result_t next_res;
  bssim_pkg::result_t out_res;

  // Configuration register write and read-back.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == bssim_pkg::RegTicksPerLine);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= bssim_pkg::TicksResetVal;
    end else if (cfg_wr) begin
      ticks_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bssim_pkg::RegTicksPerLine) begin
      prdata = {24'd0, ticks_q};
    end
  end

  // Input register.
  always_comb begin
    in_item.mode = mode_i;
    in_item.addr = addr_i;
    in_item.data = data_i;
  end

  bssim_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .down_ready_i (s2_ready),
    .valid_o      (s1_valid),
    .item_o       (s1_item)
  );

  // The request moves on when the result register can take its result.
  assign adv = s1_valid && s2_ready;

  bssim_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .item_i  (s1_item),
    .ticks_i (ticks_q),
    .res_o   (next_res)
  );

  bssim_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_valid),
    .res_i       (next_res),
    .ready_o     (s2_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  // Result fields.
  assign prg_bank_o   = out_res.prg_bank;
  assign chr_bank_0_o = out_res.chr_bank_0;
  assign chr_bank_1_o = out_res.chr_bank_1;
  assign chr_bank_2_o = out_res.chr_bank_2;
  assign chr_bank_3_o = out_res.chr_bank_3;
  assign mirroring_o  = out_res.mirroring;
  assign irq_pulse_o  = out_res.irq_pulse;
  assign irq_active_o = out_res.irq_active;
  assign irq_count_o  = out_res.irq_count;

endmodule

`default_nettype wire
